// ----- src/sobel_pkg.sv -----
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants for the thresholded Sobel edge core.
// ----------------------------------------------------------------------------
package sobel_pkg;

	localparam int PIX_W         = 8;
	localparam int THR_W         = 10;
	localparam int DIM_W         = 12;
	localparam int CFG_W         = 12;
	localparam int CFG_IDX_W     = 2;
	localparam int GRAD_W        = 11;   // signed, |G| <= 4*255
	localparam int DEF_MAX_WIDTH = 2048;
	localparam int QDEPTH        = 4;    // front-to-back queue
	localparam int ODEPTH        = 4;    // result queue

	localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd2;

	localparam logic [THR_W-1:0] RST_EDGE_THRESHOLD = 10'd64;
	localparam logic [DIM_W-1:0] RST_FRAME_WIDTH    = 12'd640;
	localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT   = 12'd480;

	// one column of the window plus what to do with it
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
		logic             produce;
		logic             last;
	} col_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] edge_value;
		logic             last_of_frame;
	} result_t;

endpackage

// ----- src/sobel_ram.sv -----
// ----------------------------------------------------------------------------
// sobel_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sobel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/sobel_fifo.sv -----
// ----------------------------------------------------------------------------
// sobel_fifo
// Small register-based FIFO with an occupancy count.
// ----------------------------------------------------------------------------
module sobel_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNW-1:0]   count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		logic [PW-1:0] n;
		if (p == PW'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PW'(1);
		end
		return n;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNW'(1);
				2'b01:   count_q <= count_q - CNW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign count = count_q;

endmodule

// ----- src/sobel_front.sv -----
// ----------------------------------------------------------------------------
// sobel_front
// Pixel intake: raster counters, line-store access and classification of
// each pixel as interior / last-of-frame. Pushes one column per pixel.
// ----------------------------------------------------------------------------
module sobel_front import sobel_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [PIX_W-1:0]            pixel_value,
	input  logic                        frame_start,
	input  logic [DIM_W-1:0]            frame_width,
	input  logic [DIM_W-1:0]            frame_height,
	input  logic [$clog2(QDEPTH+1)-1:0] q_count,
	output logic                        q_push,
	output col_item_t                   q_item
);

	localparam int CW  = $clog2(MAX_WIDTH + 1);
	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW  = (CW > DIM_W) ? CW : DIM_W;
	localparam int QCW = $clog2(QDEPTH + 1);

	logic [CW-1:0]    col_q;
	logic [DIM_W-1:0] row_q;

	logic [WW-1:0]    fw_ext;
	logic [CW-1:0]    eff_w;
	logic [DIM_W-1:0] eff_h;
	logic [CW-1:0]    col_base, col_cur;
	logic [DIM_W-1:0] row_base, row_inc, row_cur;
	logic             produce, last;
	logic             accept;
	logic [AW-1:0]    raddr;
	logic [QCW:0]     occupancy;

	logic             valid_s1;
	logic [AW-1:0]    addr_s1;
	logic [PIX_W-1:0] bot_s1;
	logic             produce_s1, last_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_top_s1, fwd_mid_s1;

	logic [PIX_W-1:0] upper_rdata, middle_rdata;
	logic [PIX_W-1:0] top_s1, mid_s1;

	// every accepted pixel is pushed into the queue in the next cycle, so count it early
	assign occupancy = (QCW+1)'(q_count) + (QCW+1)'(valid_s1);
	assign full      = occupancy >= (QCW+1)'(QDEPTH);
	assign accept    = push & ~full;

	always_comb begin
		fw_ext = WW'(frame_width);
		if (fw_ext < WW'(3)) begin
			eff_w = CW'(3);
		end else if (fw_ext > WW'(MAX_WIDTH)) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = CW'(fw_ext);
		end
		eff_h = (frame_height < DIM_W'(3)) ? DIM_W'(3) : frame_height;

		col_base = frame_start ? '0 : col_q;
		row_base = frame_start ? '0 : row_q;
		if (col_base >= eff_w) begin
			col_cur = '0;
			row_inc = row_base + DIM_W'(1);
		end else begin
			col_cur = col_base;
			row_inc = row_base;
		end
		row_cur = (row_inc >= eff_h) ? '0 : row_inc;

		produce = (row_cur >= DIM_W'(2)) && (col_cur >= CW'(2));
		last    = (row_cur == eff_h - DIM_W'(1)) && (col_cur == eff_w - CW'(1));
		raddr   = col_cur[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				col_q <= col_cur + CW'(1);
				row_q <= row_cur;
			end
		end
	end

	// line-store write of the previous pixel lands in the cycle after its read;
	// a re-read of that same column on the next pixel takes the forwarded data
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1    <= raddr;
			bot_s1     <= pixel_value;
			produce_s1 <= produce;
			last_s1    <= last;
			fwd_s1     <= valid_s1 && (addr_s1 == raddr);
			fwd_top_s1 <= mid_s1;
			fwd_mid_s1 <= bot_s1;
		end
	end

	sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_s1),
		.wdata (mid_s1),
		.re    (accept),
		.raddr (raddr),
		.rdata (upper_rdata)
	);

	sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_s1),
		.wdata (bot_s1),
		.re    (accept),
		.raddr (raddr),
		.rdata (middle_rdata)
	);

	assign top_s1 = fwd_s1 ? fwd_top_s1 : upper_rdata;
	assign mid_s1 = fwd_s1 ? fwd_mid_s1 : middle_rdata;

	assign q_push         = valid_s1;
	assign q_item.top     = top_s1;
	assign q_item.mid     = mid_s1;
	assign q_item.bot     = bot_s1;
	assign q_item.produce = produce_s1;
	assign q_item.last    = last_s1;

endmodule

// ----- src/sobel_back.sv -----
// ----------------------------------------------------------------------------
// sobel_back
// Window shift and gradient datapath: Gx/Gy in one stage, then magnitude,
// threshold, sum and saturation into the result queue.
// ----------------------------------------------------------------------------
module sobel_back import sobel_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [$clog2(QDEPTH+1)-1:0] q_count,
	input  col_item_t                   q_item,
	output logic                        q_pop,
	input  logic [THR_W-1:0]            edge_threshold,
	input  logic [$clog2(ODEPTH+1)-1:0] res_count,
	output logic                        res_push,
	output result_t                     res_item
);

	localparam int OCW = $clog2(ODEPTH + 1);

	// column c-2 (left) and c-1 (centre) of the window
	logic [PIX_W-1:0] tl_q, ml_q, bl_q;
	logic [PIX_W-1:0] tc_q, mc_q, bc_q;

	logic [OCW:0]        res_occ;
	logic [GRAD_W-1:0]   pos_x, neg_x, pos_y, neg_y;
	logic                valid_s2, last_s2;
	logic signed [GRAD_W-1:0] gx_s2, gy_s2;
	logic [THR_W-1:0]    mag_x, mag_y;
	logic [THR_W:0]      sum;

	assign res_occ = (OCW+1)'(res_count) + (OCW+1)'(valid_s2);
	assign q_pop   = (q_count != '0) && (res_occ < (OCW+1)'(ODEPTH));

	always_comb begin
		pos_x = GRAD_W'(q_item.top) + (GRAD_W'(q_item.mid) << 1) + GRAD_W'(q_item.bot);
		neg_x = GRAD_W'(tl_q) + (GRAD_W'(ml_q) << 1) + GRAD_W'(bl_q);
		pos_y = GRAD_W'(tl_q) + (GRAD_W'(tc_q) << 1) + GRAD_W'(q_item.top);
		neg_y = GRAD_W'(bl_q) + (GRAD_W'(bc_q) << 1) + GRAD_W'(q_item.bot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q     <= '0;
			ml_q     <= '0;
			bl_q     <= '0;
			tc_q     <= '0;
			mc_q     <= '0;
			bc_q     <= '0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= q_pop && q_item.produce;
			if (q_pop) begin
				tl_q <= tc_q;
				ml_q <= mc_q;
				bl_q <= bc_q;
				tc_q <= q_item.top;
				mc_q <= q_item.mid;
				bc_q <= q_item.bot;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			gx_s2   <= $signed(pos_x - neg_x);
			gy_s2   <= $signed(pos_y - neg_y);
			last_s2 <= q_item.last;
		end
	end

	function automatic logic [THR_W-1:0] thr_abs(input logic signed [GRAD_W-1:0] g,
	                                             input logic [THR_W-1:0] thr);
		logic [GRAD_W-1:0] a;
		logic [THR_W-1:0]  m;
		a = g[GRAD_W-1] ? GRAD_W'(-g) : GRAD_W'(g);
		m = a[THR_W-1:0];
		return (m < thr) ? '0 : m;
	endfunction

	always_comb begin
		mag_x = thr_abs(gx_s2, edge_threshold);
		mag_y = thr_abs(gy_s2, edge_threshold);
		sum   = (THR_W+1)'(mag_x) + (THR_W+1)'(mag_y);
	end

	assign res_push               = valid_s2;
	assign res_item.edge_value    = (sum > (THR_W+1)'(255)) ? 8'hFF : sum[PIX_W-1:0];
	assign res_item.last_of_frame = last_s2;

endmodule

// ----- src/sobel_edge_thresholded_core.sv -----
// ----------------------------------------------------------------------------
// sobel_edge_thresholded_core
// 3x3 Sobel edge detector with per-gradient threshold and saturated output.
// ----------------------------------------------------------------------------
// Takes one 8-bit grey pixel per clock in raster order and returns one edge
// value for every interior pixel (none for the frame border), so it sustains
// one pixel per cycle as long as results are popped. A result passes from the
// pixel that completes its 3x3 window through the line-store RAM read, the
// column queue and the gradient stage into the result queue. full rises only
// when the column queue backs up behind a stalled result side. frame_start on
// a pixel restarts the raster counters; the user must write registers
// (threshold, width, height) only while idle, as the core does not enforce it.
// Line stores are not cleared after reset; the first two rows of a frame
// never produce results, so no stale data reaches the output.
// ----------------------------------------------------------------------------
module sobel_edge_thresholded_core import sobel_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic [PIX_W-1:0]     pixel_value,
	input  logic                 frame_start,
	output logic                 empty,
	input  logic                 pop,
	output logic [PIX_W-1:0]     edge_value,
	output logic                 last_of_frame
);

	logic [THR_W-1:0] edge_threshold_q;
	logic [DIM_W-1:0] frame_width_q;
	logic [DIM_W-1:0] frame_height_q;

	logic [$clog2(QDEPTH+1)-1:0] q_count;
	logic                        q_push, q_pop;
	col_item_t                   q_wdata, q_rdata;

	logic [$clog2(ODEPTH+1)-1:0] res_count;
	logic                        res_push, res_pop;
	result_t                     res_wdata, res_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_threshold_q <= RST_EDGE_THRESHOLD;
			frame_width_q    <= RST_FRAME_WIDTH;
			frame_height_q   <= RST_FRAME_HEIGHT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_EDGE_THRESHOLD: edge_threshold_q <= cfg_data[THR_W-1:0];
				REG_FRAME_WIDTH:    frame_width_q    <= cfg_data[DIM_W-1:0];
				REG_FRAME_HEIGHT:   frame_height_q   <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	sobel_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.pixel_value  (pixel_value),
		.frame_start  (frame_start),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.q_count      (q_count),
		.q_push       (q_push),
		.q_item       (q_wdata)
	);

	sobel_fifo #(.WIDTH($bits(col_item_t)), .DEPTH(QDEPTH)) u_col_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.count  (q_count)
	);

	sobel_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_count        (q_count),
		.q_item         (q_rdata),
		.q_pop          (q_pop),
		.edge_threshold (edge_threshold_q),
		.res_count      (res_count),
		.res_push       (res_push),
		.res_item       (res_wdata)
	);

	assign empty   = (res_count == '0);
	assign res_pop = pop & ~empty;

	sobel_fifo #(.WIDTH($bits(result_t)), .DEPTH(ODEPTH)) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.pop    (res_pop),
		.rdata  (res_rdata),
		.count  (res_count)
	);

	assign edge_value    = res_rdata.edge_value;
	assign last_of_frame = res_rdata.last_of_frame;

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the thresholded 3x3 Sobel edge core.
// ----------------------------------------------------------------------------
// Pixels are pushed from a backlog by a clocked driver. Each accepted pixel
// runs through a local raster/window predictor that queues the edge result it
// should cause. The monitor pops results under random stalls and checks each
// field against the oldest queued result. Geometry and threshold change only
// while the core is drained. The run covers hand-built frames, geometry
// changes between pixels of a frame, the tallest frame with a clamped width,
// and random frames with broken and back-to-back sequences.
// ----------------------------------------------------------------------------
module tb import sobel_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;   // not a register
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS  = 840;

	typedef struct {
		logic [PIX_W-1:0] level;
		logic             sof;
	} pixel_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 push = 1'b0;
	logic                 full;
	logic [PIX_W-1:0]     pixel_value = '0;
	logic                 frame_start = 1'b0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [PIX_W-1:0]     edge_value;
	logic                 last_of_frame;

	sobel_edge_thresholded_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.pixel_value  (pixel_value),
		.frame_start  (frame_start),
		.empty        (empty),
		.pop          (pop),
		.edge_value   (edge_value),
		.last_of_frame(last_of_frame)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [THR_W-1:0] thr_cfg = RST_EDGE_THRESHOLD;
	logic [DIM_W-1:0] width_cfg = RST_FRAME_WIDTH;
	logic [DIM_W-1:0] height_cfg = RST_FRAME_HEIGHT;
	logic [PIX_W-1:0] upper_row [DEF_MAX_WIDTH];
	logic [PIX_W-1:0] middle_row [DEF_MAX_WIDTH];
	logic [PIX_W-1:0] win [6] = '{default: '0};
	int unsigned      col_pos = 0;
	int unsigned      row_pos = 0;

	pixel_t  pixel_backlog [$];
	result_t expected_edges [$];
	int      queued_count = 0;
	int      sent_count = 0;
	int      error_count = 0;
	int      cycle_count = 0;
	int      send_idle_pct = 26;
	int      recv_idle_pct = 78;
	int      hold_request = 0;
	int      hold_left = 0;

	function automatic int gate_magnitude(input int g);
		if (g < 0)
			g = -g;
		if (g < int'(thr_cfg))
			g = 0;
		return g;
	endfunction

	// advance the raster position by one pixel; returns 1 when a result is due
	function automatic bit predict_edge(input logic [PIX_W-1:0] px, input logic sof,
			output result_t res);
		int unsigned w, h, c, r;
		logic [PIX_W-1:0] top, mid;
		int gx, gy, sum;
		bit hit;
		w = 32'(width_cfg);
		if (w < 3)
			w = 3;
		if (w > DEF_MAX_WIDTH)
			w = DEF_MAX_WIDTH;
		h = (height_cfg < 3) ? 3 : 32'(height_cfg);
		if (sof) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		c = col_pos;
		r = row_pos;
		top = upper_row[c];
		mid = middle_row[c];
		hit = (r >= 2 && c >= 2);
		res = '0;
		if (hit) begin
			gx = -int'(win[0]) + int'(top) - 2 * int'(win[1]) + 2 * int'(mid)
				- int'(win[2]) + int'(px);
			gy = int'(win[0]) + 2 * int'(win[3]) + int'(top) - int'(win[2])
				- 2 * int'(win[5]) - int'(px);
			sum = gate_magnitude(gx) + gate_magnitude(gy);
			if (sum > 255)
				sum = 255;
			res.edge_value = sum[PIX_W-1:0];
			res.last_of_frame = (r == h - 1 && c == w - 1);
		end
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = top;
		win[4] = mid;
		win[5] = px;
		upper_row[c] = mid;
		middle_row[c] = px;
		col_pos = c + 1;
		return hit;
	endfunction

	// driver: a transaction completes on push && !full
	always @(posedge clk) begin
		result_t res;
		pixel_t  nxt;
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				sent_count++;
				if (predict_edge(pixel_value, frame_start, res))
					expected_edges.push_back(res);
			end
			if (!push || !full) begin
				if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = pixel_backlog.pop_front();
					push <= 1'b1;
					pixel_value <= nxt.level;
					frame_start <= nxt.sof;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// receiver stalls; a hold request blocks pops for a long stretch
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
			pop <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (expected_edges.size() == 0) begin
				$error("unexpected transaction: edge_value %0d last_of_frame %0b",
					edge_value, last_of_frame);
				error_count++;
			end else begin
				want = expected_edges.pop_front();
				if (edge_value !== want.edge_value) begin
					$error("edge_value: expected %0d, got %0d", want.edge_value, edge_value);
					error_count++;
				end
				if (last_of_frame !== want.last_of_frame) begin
					$error("last_of_frame: expected %0b, got %0b",
						want.last_of_frame, last_of_frame);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	task automatic queue_pixel(input logic [PIX_W-1:0] level, input logic sof);
		pixel_t p;
		p.level = level;
		p.sof = sof;
		pixel_backlog.push_back(p);
		queued_count++;
	endtask

	function automatic logic [PIX_W-1:0] rand_level();
		case ($urandom_range(3))
			0: return PIX_W'($urandom_range(255));
			1: return $urandom_range(1) ? 8'd255 : 8'd0;
			2: return PIX_W'($urandom_range(15));
			default: return PIX_W'($urandom_range(255, 240));
		endcase
	endfunction

	task automatic queue_run(input int count, input logic sof);
		for (int i = 0; i < count; i++)
			queue_pixel(rand_level(), sof && i == 0);
	endtask

	// every pixel accepted, every result popped, then let the pipe empty
	task automatic wait_drained();
		while (sent_count != queued_count || expected_edges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write enable stays high across back-to-back writes; close with end_writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_EDGE_THRESHOLD: thr_cfg = data[THR_W-1:0];
			REG_FRAME_WIDTH:    width_cfg = data;
			REG_FRAME_HEIGHT:   height_cfg = data;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		logic [PIX_W-1:0] step_frame [16];
		int random_items;
		int w_eff, h_eff, frames, npix, cut, phase_no;
		logic [CFG_W-1:0] w_reg, h_reg;
		logic [THR_W-1:0] thr;
		logic sof;
		step_frame = '{8'd0, 8'd0, 8'd255, 8'd255,
			8'd0, 8'd0, 8'd255, 8'd255,
			8'd255, 8'd255, 8'd0, 8'd0,
			8'd255, 8'd255, 8'd255, 8'd255};
		random_items = 0;
		phase_no = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// 4x4 step pattern at the reset threshold: saturated results
		write_reg(REG_FRAME_WIDTH, 12'd4);
		write_reg(REG_FRAME_HEIGHT, 12'd4);
		write_reg(REG_SPARE, 12'hFFF);
		end_writes();
		for (int i = 0; i < 16; i++)
			queue_pixel(step_frame[i], i == 0);
		wait_drained();

		// 3x3 ramp, zero threshold written with bits above its width
		write_reg(REG_EDGE_THRESHOLD, 12'hC00);
		write_reg(REG_FRAME_WIDTH, 12'd3);
		write_reg(REG_FRAME_HEIGHT, 12'd3);
		end_writes();
		for (int i = 0; i < 9; i++)
			queue_pixel(PIX_W'(i + 1), i == 0);
		wait_drained();

		// width, then height shrunk partway through a frame
		write_reg(REG_EDGE_THRESHOLD, 12'd30);
		write_reg(REG_FRAME_WIDTH, 12'd8);
		write_reg(REG_FRAME_HEIGHT, 12'd5);
		end_writes();
		queue_run(21, 1'b1);
		wait_drained();
		write_reg(REG_FRAME_WIDTH, 12'd5);
		end_writes();
		queue_run(7, 1'b0);
		wait_drained();
		write_reg(REG_FRAME_HEIGHT, 12'd3);
		end_writes();
		queue_run(40, 1'b0);
		wait_drained();

		// tallest frame with clamped width, part of it only; long receiver
		// hold so the core fills up and pushes back
		send_idle_pct = 26;
		recv_idle_pct = 78;
		write_reg(REG_EDGE_THRESHOLD, 12'h3FF);
		write_reg(REG_FRAME_WIDTH, 12'd0);
		write_reg(REG_FRAME_HEIGHT, 12'hFFF);
		end_writes();
		hold_request = 150;
		queue_run(120, 1'b1);
		wait_drained();

		// random geometry: mostly whole frames, some cut short or chained
		while (random_items < RANDOM_ITEMS) begin
			if (random_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 26;
				recv_idle_pct = 78;
			end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 78;
				recv_idle_pct = 26;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case ($urandom_range(4))
				0: thr = '0;
				1: thr = '1;
				2: thr = RST_EDGE_THRESHOLD;
				default: thr = THR_W'($urandom_range(300));
			endcase
			case ($urandom_range(5))
				0: w_reg = CFG_W'($urandom_range(2));
				1: w_reg = 12'd3;
				2, 3: w_reg = CFG_W'($urandom_range(10, 4));
				4: w_reg = CFG_W'($urandom_range(40, 11));
				default: w_reg = CFG_W'($urandom_range(8, 3));
			endcase
			case ($urandom_range(3))
				0: h_reg = CFG_W'($urandom_range(2));
				1: h_reg = 12'd3;
				default: h_reg = CFG_W'($urandom_range(8, 4));
			endcase
			w_eff = (w_reg < 3) ? 3 : int'(w_reg);
			h_eff = (h_reg < 3) ? 3 : int'(h_reg);
			write_reg(REG_EDGE_THRESHOLD, {CFG_W'($urandom_range(3)) << THR_W} | CFG_W'(thr));
			write_reg(REG_FRAME_WIDTH, w_reg);
			write_reg(REG_FRAME_HEIGHT, h_reg);
			end_writes();
			if (phase_no == 0)
				hold_request = 150;
			frames = $urandom_range(3, 1);
			sof = 1'b1;
			for (int f = 0; f < frames; f++) begin
				npix = w_eff * h_eff;
				cut = ($urandom_range(7) == 0) ? $urandom_range(npix, 1) : npix;
				if (cut > RANDOM_ITEMS - random_items)
					cut = RANDOM_ITEMS - random_items;
				queue_run(cut, sof);
				random_items += cut;
				// a cut frame must be followed by a marked start
				sof = (cut != npix) ? 1'b1 : logic'($urandom_range(1));
			end
			phase_no++;
			wait_drained();
		end

		if (expected_edges.size() != 0) begin
			$error("%0d expected transactions never arrived", expected_edges.size());
			error_count++;
		end
		if (error_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ----- sim.f -----
src/sobel_pkg.sv
src/sobel_ram.sv
src/sobel_fifo.sv
src/sobel_front.sv
src/sobel_back.sv
src/sobel_edge_thresholded_core.sv
test/tb.sv
